/* rtl/zeet_pkg.sv */
package zeet_pkg;

  // Sizes of the block.
  localparam int ZONES        = 4;
  localparam int MAX_VERTICES = 16;
  localparam int MAX_TRACKS   = 64;
  localparam int COORD_BITS   = 16;

  localparam int ZONE_W    = $clog2(ZONES);
  localparam int SLOT_W    = $clog2(MAX_VERTICES);
  localparam int ADDR_W    = ZONE_W + SLOT_W;
  localparam int DEPTH     = ZONES * MAX_VERTICES;
  localparam int CNT_W     = SLOT_W + 1;
  localparam int TRACK_W   = 6;
  localparam int INSIDE_W  = 7;
  localparam int TOTAL_W   = 32;
  localparam int DIFF_W    = COORD_BITS + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int MIN_VERTS = 3;

  // The frame maps are counted one chunk per cycle.
  localparam int CHUNK_W   = 8;
  localparam int CHUNKS    = MAX_TRACKS / CHUNK_W;
  localparam int CHUNK_IW  = $clog2(CHUNKS);

  // Stages of the edge pipeline between a vertex read and the update of the inside map.
  localparam int PIPE_DEPTH = 3;
  localparam int DRAIN_W    = 2;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_TRACK = 2'd1,
    ACT_FRAME = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_EXIT  = 2'd2
  } event_e;

  typedef struct packed {
    logic [1:0]                   action;
    logic [ZONE_W-1:0]            zone;
    logic [SLOT_W-1:0]            vertex_index;
    logic                         vertex_last;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [TRACK_W-1:0]           track_id;
  } in_item_t;

  typedef struct packed {
    logic [ZONE_W-1:0]   zone_out;
    event_e              event_kind;
    logic [TRACK_W-1:0]  event_track;
    logic [INSIDE_W-1:0] inside_count;
    logic [TOTAL_W-1:0]  entry_total;
    logic                last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load_we;
    logic                latch_track;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                rd_edge;
    logic                rd_last;
    logic                frame_start;
    logic                cnt_step;
    logic [CHUNK_IW-1:0] cnt_idx;
    logic                frame_commit;
    logic                emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ZONES-1:0][CNT_W-1:0] counts;
    logic                        out_free;
    logic                        emit_last;
  } sts_t;

  // Index of the lowest set bit, zero when none is set.
  function automatic logic [TRACK_W-1:0] lowest_one(input logic [MAX_TRACKS-1:0] v);
    logic [TRACK_W-1:0] idx;
    idx = '0;
    for (int i = MAX_TRACKS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = TRACK_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

/* rtl/zeet_if.sv */
// Input channel.
interface zeet_in_if;
  logic               valid;
  logic               ready;
  zeet_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result channel.
interface zeet_out_if;
  logic                valid;
  logic                ready;
  zeet_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/zeet_datapath.sv */
module zeet_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  zeet_pkg::in_item_t  in_data_i,
  input  zeet_pkg::cmd_t      cmd_i,
  output zeet_pkg::sts_t      sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output zeet_pkg::out_item_t out_data_o
);

  localparam int CW = zeet_pkg::COORD_BITS;
  localparam int NT = zeet_pkg::MAX_TRACKS;

  typedef struct packed {
    logic                        valid;
    logic                        edge_ok;
    logic                        last;
    logic [zeet_pkg::ZONE_W-1:0] zone;
  } tag_t;

  // Vertex memory, {x, y} per entry.
  logic [2*CW-1:0] vmem_q [zeet_pkg::DEPTH];
  logic [2*CW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      vmem_q[{in_data_i.zone, in_data_i.vertex_index}] <= {in_data_i.x, in_data_i.y};
    end
    if (cmd_i.rd_en) begin
      rdata_q <= vmem_q[cmd_i.rd_addr];
    end
  end

  // Vertex counts per zone.
  logic [zeet_pkg::ZONES-1:0][zeet_pkg::CNT_W-1:0] counts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counts_q <= '0;
    end else if (cmd_i.load_we && in_data_i.vertex_last) begin
      counts_q[in_data_i.zone] <= {1'b0, in_data_i.vertex_index} + zeet_pkg::CNT_W'(1);
    end
  end

  // Track position under test.
  logic signed [CW-1:0]          px_q, py_q;
  logic [zeet_pkg::TRACK_W-1:0]  trk_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_track) begin
      px_q  <= in_data_i.x;
      py_q  <= in_data_i.y;
      trk_q <= in_data_i.track_id;
    end
  end

  // Tags that travel with the edge pipeline.
  tag_t t1_q, t2_q, t3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0;
      t2_q <= '0;
      t3_q <= '0;
    end else begin
      t1_q <= '{valid: cmd_i.rd_en, edge_ok: cmd_i.rd_edge, last: cmd_i.rd_last,
                zone: cmd_i.rd_addr[zeet_pkg::ADDR_W-1 -: zeet_pkg::ZONE_W]};
      t2_q <= t1_q;
      t3_q <= t2_q;
    end
  end

  // Stage one: differences against the previous vertex.
  logic signed [CW-1:0] ax, ay, bx_q, by_q;
  logic signed [zeet_pkg::DIFF_W-1:0] d1, lx1, ex1, ly1;
  logic straddle1;

  assign ax = rdata_q[2*CW-1:CW];
  assign ay = rdata_q[CW-1:0];
  assign straddle1 = (ay > py_q) != (by_q > py_q);
  assign d1  = zeet_pkg::DIFF_W'(by_q) - zeet_pkg::DIFF_W'(ay);
  assign lx1 = zeet_pkg::DIFF_W'(px_q) - zeet_pkg::DIFF_W'(ax);
  assign ex1 = zeet_pkg::DIFF_W'(bx_q) - zeet_pkg::DIFF_W'(ax);
  assign ly1 = zeet_pkg::DIFF_W'(py_q) - zeet_pkg::DIFF_W'(ay);

  logic signed [zeet_pkg::DIFF_W-1:0] d_q, lx_q, ex_q, ly_q;
  logic str2_q, dpos2_q;

  always_ff @(posedge clk_i) begin
    if (t1_q.valid) begin
      bx_q <= ax;
      by_q <= ay;
    end
    str2_q  <= straddle1;
    dpos2_q <= !d1[zeet_pkg::DIFF_W-1];
    d_q     <= d1;
    lx_q    <= lx1;
    ex_q    <= ex1;
    ly_q    <= ly1;
  end

  // Stage two: the two cross products.
  logic signed [zeet_pkg::PROD_W-1:0] p1_q, p2_q;
  logic str3_q, dpos3_q;

  always_ff @(posedge clk_i) begin
    p1_q    <= lx_q * d_q;
    p2_q    <= ex_q * ly_q;
    str3_q  <= str2_q;
    dpos3_q <= dpos2_q;
  end

  // Stage three: compare, flip the parity, record the zone result.
  logic cross3, par_q, par_nxt;
  logic [zeet_pkg::ZONES-1:0][NT-1:0] cur_q, prev_q;

  assign cross3  = dpos3_q ? (p1_q < p2_q) : (p2_q < p1_q);
  assign par_nxt = par_q ^ (t3_q.edge_ok && str3_q && cross3);

  // Frame work registers.
  logic [zeet_pkg::ZONE_W-1:0]   fz_q;
  logic [NT-1:0]                 curw_q, ent_q, ext_q;
  logic [zeet_pkg::INSIDE_W-1:0] inc_q, enc_q;
  logic [zeet_pkg::ZONES-1:0][zeet_pkg::TOTAL_W-1:0] ectr_q;
  logic [zeet_pkg::TOTAL_W-1:0]  tot_q;
  logic [zeet_pkg::TOTAL_W-1:0]  ectr_sum;

  assign ectr_sum = ectr_q[fz_q] + zeet_pkg::TOTAL_W'(enc_q);

  function automatic logic [zeet_pkg::INSIDE_W-1:0] pop8(
    input logic [zeet_pkg::CHUNK_W-1:0] v);
    logic [zeet_pkg::INSIDE_W-1:0] c;
    c = '0;
    for (int i = 0; i < zeet_pkg::CHUNK_W; i++) begin
      c = c + zeet_pkg::INSIDE_W'(v[i]);
    end
    return c;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_q  <= 1'b0;
      cur_q  <= '0;
      prev_q <= '0;
      ectr_q <= '0;
    end else begin
      if (t3_q.valid) begin
        if (t3_q.last) begin
          par_q <= 1'b0;
          if (par_nxt) begin
            cur_q[t3_q.zone][trk_q] <= 1'b1;
          end
        end else begin
          par_q <= par_nxt;
        end
      end
      if (cmd_i.frame_commit) begin
        ectr_q[fz_q] <= ectr_sum;
        prev_q[fz_q] <= curw_q;
        cur_q[fz_q]  <= '0;
      end
    end
  end

  // Event selection for the next result beat.
  logic [NT-1:0]                ent_nxt, ext_nxt, pick;
  logic [zeet_pkg::TRACK_W-1:0] pick_idx;
  zeet_pkg::event_e             kind;
  logic                         emit_last;

  always_comb begin
    ent_nxt = ent_q;
    ext_nxt = ext_q;
    pick    = (ent_q != '0) ? ent_q : ext_q;
    kind    = zeet_pkg::EV_NONE;
    if (ent_q != '0) begin
      kind    = zeet_pkg::EV_ENTER;
      ent_nxt = ent_q & (ent_q - NT'(1));
    end else if (ext_q != '0) begin
      kind    = zeet_pkg::EV_EXIT;
      ext_nxt = ext_q & (ext_q - NT'(1));
    end
    pick_idx  = (kind == zeet_pkg::EV_NONE) ? '0 : zeet_pkg::lowest_one(pick);
    emit_last = (ent_nxt == '0) && (ext_nxt == '0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.frame_start) begin
      fz_q   <= in_data_i.zone;
      curw_q <= cur_q[in_data_i.zone];
      ent_q  <= cur_q[in_data_i.zone] & ~prev_q[in_data_i.zone];
      ext_q  <= prev_q[in_data_i.zone] & ~cur_q[in_data_i.zone];
      inc_q  <= '0;
      enc_q  <= '0;
    end else if (cmd_i.emit) begin
      ent_q <= ent_nxt;
      ext_q <= ext_nxt;
    end
    if (cmd_i.cnt_step) begin
      inc_q <= inc_q + pop8(curw_q[int'(cmd_i.cnt_idx) * zeet_pkg::CHUNK_W +: zeet_pkg::CHUNK_W]);
      enc_q <= enc_q + pop8(ent_q[int'(cmd_i.cnt_idx) * zeet_pkg::CHUNK_W +: zeet_pkg::CHUNK_W]);
    end
    if (cmd_i.frame_commit) begin
      tot_q <= ectr_sum;
    end
  end

  // Output register.
  logic                ov_q;
  zeet_pkg::out_item_t od_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      od_q <= '{zone_out: fz_q, event_kind: kind, event_track: pick_idx,
                inside_count: inc_q, entry_total: tot_q, last: emit_last};
    end
  end

  assign out_valid_o      = ov_q;
  assign out_data_o       = od_q;
  assign sts_o.counts     = counts_q;
  assign sts_o.out_free   = !ov_q || out_ready_i;
  assign sts_o.emit_last  = emit_last;

`ifndef SYNTHESIS
  // A new track or frame never starts while edge tests are still in flight.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.latch_track || cmd_i.frame_start) |-> !(t1_q.valid || t2_q.valid || t3_q.valid))
    else $error("item started with edge tests in flight");

  // The final beat of a frame leaves no pending events behind.
  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && emit_last) |=> (ent_q == '0 && ext_q == '0))
    else $error("events left after final beat");

  // A beat is loaded only into a free output register.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!ov_q || out_ready_i))
    else $error("output register overwritten");
`endif

endmodule

/* rtl/zeet_ctrl.sv */
module zeet_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      in_action_i,
  output logic            in_ready_o,
  input  zeet_pkg::sts_t  sts_i,
  output zeet_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WALK   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_COUNT  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  localparam logic [zeet_pkg::ZONE_W-1:0]  LAST_ZONE  = zeet_pkg::ZONE_W'(zeet_pkg::ZONES - 1);
  localparam logic [zeet_pkg::CHUNK_IW-1:0] LAST_CHUNK =
    zeet_pkg::CHUNK_IW'(zeet_pkg::CHUNKS - 1);
  localparam logic [zeet_pkg::DRAIN_W-1:0] LAST_DRAIN =
    zeet_pkg::DRAIN_W'(zeet_pkg::PIPE_DEPTH - 1);

  logic [2:0]                     state_q, state_d;
  logic [zeet_pkg::ZONE_W-1:0]    zone_q, zone_d;
  logic [zeet_pkg::SLOT_W-1:0]    k_q, k_d;
  logic                           prime_q, prime_d;
  logic [zeet_pkg::DRAIN_W-1:0]   dr_q, dr_d;
  logic [zeet_pkg::CHUNK_IW-1:0]  cnt_q, cnt_d;
  logic [zeet_pkg::CNT_W-1:0]     n;
  logic [zeet_pkg::CNT_W-1:0]     n_m1;
  logic                           accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign n          = sts_i.counts[zone_q];
  assign n_m1       = n - zeet_pkg::CNT_W'(1);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    zone_d  = zone_q;
    k_d     = k_q;
    prime_d = prime_q;
    dr_d    = dr_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.cnt_idx = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_action_i)
            zeet_pkg::ACT_LOAD: begin
              cmd_o.load_we = 1'b1;
            end
            zeet_pkg::ACT_TRACK: begin
              cmd_o.latch_track = 1'b1;
              zone_d  = '0;
              prime_d = 1'b1;
              state_d = S_WALK;
            end
            zeet_pkg::ACT_FRAME: begin
              cmd_o.frame_start = 1'b1;
              cnt_d   = '0;
              state_d = S_COUNT;
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        if (n < zeet_pkg::CNT_W'(zeet_pkg::MIN_VERTS) || !prime_q) begin
          if (n >= zeet_pkg::CNT_W'(zeet_pkg::MIN_VERTS)) begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_edge = 1'b1;
            cmd_o.rd_addr = {zone_q, k_q};
            cmd_o.rd_last = ({1'b0, k_q} == n_m1);
            k_d = k_q + zeet_pkg::SLOT_W'(1);
          end
          // Move on after the closing edge or for a zone too small to test.
          if (n < zeet_pkg::CNT_W'(zeet_pkg::MIN_VERTS) || ({1'b0, k_q} == n_m1)) begin
            prime_d = 1'b1;
            if (zone_q == LAST_ZONE) begin
              dr_d    = '0;
              state_d = S_DRAIN;
            end else begin
              zone_d = zone_q + zeet_pkg::ZONE_W'(1);
            end
          end
        end else begin
          // Read the last vertex first so the first edge closes the polygon.
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = {zone_q, n_m1[zeet_pkg::SLOT_W-1:0]};
          prime_d = 1'b0;
          k_d     = '0;
        end
      end
      S_DRAIN: begin
        if (dr_q == LAST_DRAIN) begin
          state_d = S_IDLE;
        end else begin
          dr_d = dr_q + zeet_pkg::DRAIN_W'(1);
        end
      end
      S_COUNT: begin
        cmd_o.cnt_step = 1'b1;
        if (cnt_q == LAST_CHUNK) begin
          state_d = S_COMMIT;
        end else begin
          cnt_d = cnt_q + zeet_pkg::CHUNK_IW'(1);
        end
      end
      S_COMMIT: begin
        cmd_o.frame_commit = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      zone_q  <= '0;
      k_q     <= '0;
      prime_q <= 1'b1;
      dr_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      zone_q  <= zone_d;
      k_q     <= k_d;
      prime_q <= prime_d;
      dr_q    <= dr_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  // Every vertex read falls inside the zone's loaded polygon.
  a_rd_in_poly: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |-> ({1'b0, cmd_o.rd_addr[zeet_pkg::SLOT_W-1:0]} <
      sts_i.counts[cmd_o.rd_addr[zeet_pkg::ADDR_W-1 -: zeet_pkg::ZONE_W]]))
    else $error("vertex read beyond zone count");
`endif

endmodule

/* rtl/zone_entry_exit_tracker_unit.sv */
// Track item: each zone with three or more vertices reads its last vertex and then every vertex
// in turn, smaller zones are skipped, then the edge pipeline drains.
// End-of-frame item: the maps are counted chunk by chunk and committed, then one result beat
// per event (at least one) as the sink takes them; the vertex memory's single read port
// sets the track rate. Load items are written as they are accepted. Reset is asynchronous
// and active low; it clears counts, inside maps and entry counters, not the vertex memory.
module zone_entry_exit_tracker_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  zeet_in_if.sink    in_i,
  zeet_out_if.source out_o
);

  zeet_pkg::cmd_t cmd;
  zeet_pkg::sts_t sts;

  zeet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.data.action),
    .in_ready_o  (in_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  zeet_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data)
  );

endmodule
